// ===== rtl/mwbs_pkg.sv =====
`default_nettype none
package mwbs_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
  localparam logic [7:0] ST_MTC_QFRAME   = 8'hF1;
  localparam logic [7:0] ST_SONG_POS     = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL     = 8'hF3;
  localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
  localparam logic [3:0] HI_NOTE_ON      = 4'h9;
  localparam logic [3:0] HI_POLY_PRESS   = 4'hA;
  localparam logic [3:0] HI_CTRL_CHANGE  = 4'hB;
  localparam logic [3:0] HI_PROG_CHANGE  = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND   = 4'hE;
  localparam logic [3:0] HI_SYSTEM       = 4'hF;

  // One queued word and the index of the last byte to send from it.
  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  last_idx;
  } entry_t;

  // Head of the queue as seen by the byte sender.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

  // Index of the last byte of a non-sysex message, from its status byte.
  function automatic logic [1:0] status_last_idx(input logic [7:0] st);
    logic [1:0] idx;
    idx = 2'd0;
    unique case (st[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESS, HI_CTRL_CHANGE, HI_PITCH_BEND: idx = 2'd2;
      HI_PROG_CHANGE, HI_CHAN_PRESS: idx = 2'd1;
      HI_SYSTEM: begin
        if (st == ST_MTC_QFRAME || st == ST_SONG_SEL) begin
          idx = 2'd1;
        end else if (st == ST_SONG_POS) begin
          idx = 2'd2;
        end else begin
          idx = 2'd0;
        end
      end
      default: idx = 2'd0;
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mwbs_front.sv =====
`default_nettype none
module mwbs_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [31:0]     in_tdata,
  input  wire logic            queue_full,
  output logic                 push,
  output mwbs_pkg::entry_t     push_entry
);

  logic       in_sysex_r;
  logic       in_sysex_nxt;
  logic       enqueue;
  logic [7:0] st;
  logic       accept;

  assign st        = in_tdata[7:0];
  assign in_tready = !queue_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && enqueue;

  always_comb begin
    in_sysex_nxt        = in_sysex_r;
    enqueue             = 1'b1;
    push_entry.word     = in_tdata;
    push_entry.last_idx = 2'd0;
    priority if (st >= mwbs_pkg::ST_REALTIME_MIN) begin
      push_entry.last_idx = 2'd0;
    end else if (in_sysex_r || st == mwbs_pkg::ST_SYSEX_START) begin
      // The run stops after the first end-of-exclusive byte in the word.
      in_sysex_nxt = 1'b0;
      priority if (in_tdata[7:0] == mwbs_pkg::ST_SYSEX_END) begin
        push_entry.last_idx = 2'd0;
      end else if (in_tdata[15:8] == mwbs_pkg::ST_SYSEX_END) begin
        push_entry.last_idx = 2'd1;
      end else if (in_tdata[23:16] == mwbs_pkg::ST_SYSEX_END) begin
        push_entry.last_idx = 2'd2;
      end else if (in_tdata[31:24] == mwbs_pkg::ST_SYSEX_END) begin
        push_entry.last_idx = 2'd3;
      end else begin
        push_entry.last_idx = 2'd3;
        in_sysex_nxt        = 1'b1;
      end
    end else if (st == 8'h00) begin
      enqueue = 1'b0;
    end else begin
      push_entry.last_idx = mwbs_pkg::status_last_idx(st);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r <= 1'b0;
    end else if (accept) begin
      in_sysex_r <= in_sysex_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mwbs_queue.sv =====
`default_nettype none
module mwbs_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mwbs_pkg::entry_t  push_entry,
  output logic                   full,
  input  wire logic              pop,
  output mwbs_pkg::head_t        head
);

  mwbs_pkg::entry_t                 slot_r [mwbs_pkg::QUEUE_DEPTH];
  logic [mwbs_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [mwbs_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [mwbs_pkg::QUEUE_AW:0]      count_r;
  logic [mwbs_pkg::QUEUE_AW:0]      count_nxt;

  assign full        = (count_r == (mwbs_pkg::QUEUE_AW+1)'(mwbs_pkg::QUEUE_DEPTH));
  assign head.valid  = (count_r != '0);
  assign head.entry  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mwbs_back.sv =====
`default_nettype none
module mwbs_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mwbs_pkg::head_t   head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);

  logic [1:0] idx_r;
  logic       out_tvalid_r;
  logic [7:0] out_tdata_r;
  logic       out_tlast_r;
  logic       load;
  logic       is_last;
  logic [7:0] cur_byte;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The output register takes a new byte when empty or being drained.
  assign load     = head.valid && (!out_tvalid_r || out_tready);
  assign is_last  = (idx_r == head.entry.last_idx);
  assign pop      = load && is_last;
  assign cur_byte = head.entry.word[{idx_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (load) begin
      out_tdata_r <= cur_byte;
      out_tlast_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= 2'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (load) begin
        out_tvalid_r <= 1'b1;
        idx_r        <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/midi_word_to_byte_stream_top.sv =====
`default_nettype none
// Channel   Direction  Ports                       Payload
// in_*      slave      tvalid tready tdata[31:0]   message_word
// out_*     master     tvalid tready tdata[7:0]    data_byte, tlast = last_of_run
//
// The classifier is combinational, and each word yields 0 to 4 bytes, which the byte
// sender sends one byte per cycle while out_tready allows it, through a single-byte
// output register.
// A two-entry queue between classifier and sender lets input and output stall apart.
// Reset (rst_n low, synchronous) empties the queue and clears the sysex flag.
module midi_word_to_byte_stream_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] message_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] data_byte
  output logic             out_tlast
);

  logic              queue_full;
  logic              push;
  logic              pop;
  mwbs_pkg::entry_t  push_entry;
  mwbs_pkg::head_t   head;

  mwbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  mwbs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head)
  );

  mwbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
